// File: rtl/core/multi_radix_number_parser_assert.svh
// Assertion macros for the multi-radix number parser.
`ifndef MULTI_RADIX_NUMBER_PARSER_ASSERT_SVH
`define MULTI_RADIX_NUMBER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MRNP_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRNP_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mrnp_pkg.sv
// Shared types and constants of the multi-radix number parser.
package mrnp_pkg;

  localparam int DEF_COUNT_WIDTH = 8;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_SKIP = 7'b0000010,
    PH_ZERO = 7'b0000100,
    PH_HEX  = 7'b0001000,
    PH_OCT  = 7'b0010000,
    PH_BIN  = 7'b0100000,
    PH_DEC  = 7'b1000000
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // Radix kinds.
  localparam logic [2:0] RK_DEC  = 3'd0;
  localparam logic [2:0] RK_HEX  = 3'd1;
  localparam logic [2:0] RK_OCT  = 3'd2;
  localparam logic [2:0] RK_BIN  = 3'd3;
  localparam logic [2:0] RK_ZERO = 3'd4;

  // Characters the parser looks for.
  localparam logic [7:0] CH_BLANK_MAX = 8'd32;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UB = 8'h42;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_LX = 8'h78;

  localparam logic [31:0] DEC_LIMIT  = 32'd429496729;
  localparam logic [31:0] HEX_MASK   = 32'hF000_0000;
  localparam logic [31:0] OCT_MASK   = 32'hE000_0000;
  localparam logic [31:0] BIN_MASK   = 32'h8000_0000;
  localparam logic [31:0] OVF_VALUE  = 32'h00FF_FFFF;

  // One character held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       first;
  } stage_t;

  // One parse result.
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [2:0]  radix_kind;
    logic [7:0]  consumed;
  } result_t;

endpackage

// File: rtl/core/mrnp_if.sv
// Valid/ready channel interfaces for characters in and results out.
interface mrnp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

interface mrnp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;
  logic [2:0]  radix_kind;
  logic [7:0]  consumed;

  modport source (output valid, output value, output status, output radix_kind,
                  output consumed, input ready);
  modport sink   (input valid, input value, input status, input radix_kind,
                  input consumed, output ready);
endinterface

// File: rtl/core/multi_radix_number_parser.sv
// Top level of the multi-radix number parser: state and result registers.
//
// The chars channel carries one ASCII character per transfer, with first set
// on the character that starts a new parse. Leading blanks (bytes 1 to 32)
// are skipped, the prefix picks hex, octal, binary, lone zero or decimal, and
// the parse ends at the first character that is not a digit of its radix, or
// at once on overflow. Only that character produces a transfer on the
// results channel: value, status, radix_kind and consumed.
//
// A transferred character sits in the input register; when the step logic
// advances, it updates the parse state and, if the parse ends, loads the
// result register, from which the result is transferred. One character is
// taken every cycle while the receiver does not stall; the only loop is the
// parse state, which the step logic updates.
//
// Reset (rst, synchronous) empties both registers and leaves the parser idle:
// characters without first are dropped until a parse is started. When the
// receiver stalls, the result register holds its item, the input register
// keeps one more character, and chars.ready then falls until results moves.
module multi_radix_number_parser #(
  parameter int COUNT_WIDTH = mrnp_pkg::DEF_COUNT_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  mrnp_char_if.sink       chars,
  mrnp_result_if.source   results
);

`include "multi_radix_number_parser_assert.svh"

  mrnp_pkg::stage_t       stage;
  logic                   advance;

  mrnp_pkg::phase_t       phase;
  mrnp_pkg::phase_t       phase_next;
  logic [31:0]            acc;
  logic [31:0]            acc_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   seen;
  logic                   seen_next;
  logic                   step_emit;
  mrnp_pkg::result_t      step_result;
  logic                   step_fire;

  // The step logic moves whenever the result register is free or emptying.
  assign advance   = !results.valid || results.ready;
  assign step_fire = stage.valid && advance;

  mrnp_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .stage   (stage)
  );

  mrnp_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .stage      (stage),
    .phase      (phase),
    .acc        (acc),
    .count      (count),
    .seen       (seen),
    .phase_next (phase_next),
    .acc_next   (acc_next),
    .count_next (count_next),
    .seen_next  (seen_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  // Parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mrnp_pkg::PH_IDLE;
      acc   <= 32'd0;
      count <= '0;
      seen  <= 1'b0;
    end else if (step_fire) begin
      phase <= phase_next;
      acc   <= acc_next;
      count <= count_next;
      seen  <= seen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= step_fire && step_emit;
    end
    if (step_fire && step_emit) begin
      results.value      <= step_result.value;
      results.status     <= step_result.status;
      results.radix_kind <= step_result.radix_kind;
      results.consumed   <= step_result.consumed;
    end
  end

  // Every ended parse leaves the parser idle.
  `MRNP_ASSERT_NXT(a_idle_after_result, clk, rst, step_fire && step_emit,
                   phase == mrnp_pkg::PH_IDLE, "parser not idle after a result")

  // An overflow result carries the fixed overflow value and no count.
  `MRNP_ASSERT_IMP(a_ovf_result, clk, rst,
                   results.valid && results.status == mrnp_pkg::ST_OVF,
                   results.value == mrnp_pkg::OVF_VALUE && results.consumed == 8'd0,
                   "overflow result with wrong value or count")

  // A failed parse reports no consumed characters.
  `MRNP_ASSERT_IMP(a_none_result, clk, rst,
                   results.valid && results.status == mrnp_pkg::ST_NONE,
                   results.value == 32'd0 && results.consumed == 8'd0,
                   "no-number result with nonzero value or count")

  // Input stalls only when both registers are full and the receiver waits.
  `MRNP_ASSERT_IMP(a_stall_cause, clk, rst, !chars.ready,
                   stage.valid && results.valid && !results.ready,
                   "input stalled without a full pipeline")

endmodule

// File: rtl/core/mrnp_in_stage.sv
// Input register stage of the multi-radix number parser.
module mrnp_in_stage (
  input  logic                clk,
  input  logic                rst,
  mrnp_char_if.sink           chars,
  input  logic                advance,
  output mrnp_pkg::stage_t    stage
);

  // The held character leaves whenever the step logic advances.
  assign chars.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (chars.ready) begin
      stage.valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      stage.ch    <= chars.ch;
      stage.first <= chars.first;
    end
  end

endmodule

// File: rtl/core/mrnp_step.sv
// Per-character step logic: next parse state and the result of one character.
module mrnp_step #(
  parameter int COUNT_WIDTH = mrnp_pkg::DEF_COUNT_WIDTH
) (
  input  mrnp_pkg::stage_t        stage,
  input  mrnp_pkg::phase_t        phase,
  input  logic [31:0]             acc,
  input  logic [COUNT_WIDTH-1:0]  count,
  input  logic                    seen,
  output mrnp_pkg::phase_t        phase_next,
  output logic [31:0]             acc_next,
  output logic [COUNT_WIDTH-1:0]  count_next,
  output logic                    seen_next,
  output logic                    emit,
  output mrnp_pkg::result_t       result
);

  localparam int EXT_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  mrnp_pkg::phase_t       cur_ph;
  mrnp_pkg::phase_t       dig_ph;
  logic [31:0]            cur_acc;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] cnt_bump;
  logic [EXT_W-1:0]       cnt_ext;
  logic [7:0]             cnt_sat;
  logic                   cur_seen;
  logic [7:0]             ch;
  logic [3:0]             d;
  logic                   ok;
  logic                   ovf;
  logic [31:0]            acc_step;
  logic [2:0]             kind;
  logic                   dig_emit;
  mrnp_pkg::result_t      dig_res;

  assign ch = stage.ch;

  // A first character restarts from a clean skip phase.
  assign cur_ph   = stage.first ? mrnp_pkg::PH_SKIP : phase;
  assign cur_acc  = stage.first ? 32'd0 : acc;
  assign cur_cnt  = stage.first ? '0 : count;
  assign cur_seen = stage.first ? 1'b0 : seen;

  assign cnt_bump = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
  assign cnt_ext  = EXT_W'(cur_cnt);
  assign cnt_sat  = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[7:0];

  // Radix used for a digit step: a decimal start from skip, octal from zero.
  always_comb begin
    case (cur_ph)
      mrnp_pkg::PH_SKIP: dig_ph = mrnp_pkg::PH_DEC;
      mrnp_pkg::PH_ZERO: dig_ph = mrnp_pkg::PH_OCT;
      default:           dig_ph = cur_ph;
    endcase
  end

  always_comb begin
    d        = 4'd0;
    ok       = 1'b0;
    ovf      = 1'b0;
    acc_step = cur_acc;
    kind     = mrnp_pkg::RK_DEC;
    case (dig_ph)
      mrnp_pkg::PH_HEX: begin
        kind = mrnp_pkg::RK_HEX;
        if (ch >= mrnp_pkg::CH_0 && ch <= mrnp_pkg::CH_9) begin
          d  = 4'(ch - mrnp_pkg::CH_0);
          ok = 1'b1;
        end else if (ch >= mrnp_pkg::CH_UA && ch <= mrnp_pkg::CH_UF) begin
          d  = 4'(ch - mrnp_pkg::CH_UA + 8'd10);
          ok = 1'b1;
        end else if (ch >= mrnp_pkg::CH_LA && ch <= mrnp_pkg::CH_LF) begin
          d  = 4'(ch - mrnp_pkg::CH_LA + 8'd10);
          ok = 1'b1;
        end
        ovf      = (cur_acc & mrnp_pkg::HEX_MASK) != 32'd0;
        acc_step = {cur_acc[27:0], d};
      end
      mrnp_pkg::PH_OCT: begin
        kind = mrnp_pkg::RK_OCT;
        if (ch >= mrnp_pkg::CH_0 && ch <= mrnp_pkg::CH_7) begin
          d  = 4'(ch - mrnp_pkg::CH_0);
          ok = 1'b1;
        end
        ovf      = (cur_acc & mrnp_pkg::OCT_MASK) != 32'd0;
        acc_step = {cur_acc[28:0], d[2:0]};
      end
      mrnp_pkg::PH_BIN: begin
        kind = mrnp_pkg::RK_BIN;
        if (ch == mrnp_pkg::CH_0 || ch == mrnp_pkg::CH_1) begin
          d  = 4'(ch - mrnp_pkg::CH_0);
          ok = 1'b1;
        end
        ovf      = (cur_acc & mrnp_pkg::BIN_MASK) != 32'd0;
        acc_step = {cur_acc[30:0], d[0]};
      end
      default: begin
        if (ch >= mrnp_pkg::CH_0 && ch <= mrnp_pkg::CH_9) begin
          d  = 4'(ch - mrnp_pkg::CH_0);
          ok = 1'b1;
        end
        ovf = (cur_acc > mrnp_pkg::DEC_LIMIT) ||
              (cur_acc == mrnp_pkg::DEC_LIMIT && d > 4'd5);
        acc_step = (cur_acc << 3) + (cur_acc << 1) + 32'(d);
      end
    endcase
  end

  // Outcome of a digit step: a terminator or an overflow ends the parse.
  always_comb begin
    dig_emit = 1'b1;
    if (!ok) begin
      if (cur_seen) begin
        dig_res = '{value: cur_acc, status: mrnp_pkg::ST_FOUND, radix_kind: kind,
                    consumed: cnt_sat};
      end else begin
        dig_res = '{value: 32'd0, status: mrnp_pkg::ST_NONE, radix_kind: kind,
                    consumed: 8'd0};
      end
    end else if (ovf) begin
      dig_res = '{value: mrnp_pkg::OVF_VALUE, status: mrnp_pkg::ST_OVF,
                  radix_kind: kind, consumed: 8'd0};
    end else begin
      dig_emit = 1'b0;
      dig_res  = '{value: cur_acc, status: mrnp_pkg::ST_FOUND, radix_kind: kind,
                   consumed: cnt_sat};
    end
  end

  always_comb begin
    phase_next = cur_ph;
    acc_next   = cur_acc;
    count_next = cur_cnt;
    seen_next  = cur_seen;
    emit       = 1'b0;
    result     = dig_res;
    case (cur_ph)
      mrnp_pkg::PH_IDLE: begin
        phase_next = mrnp_pkg::PH_IDLE;
      end
      mrnp_pkg::PH_SKIP: begin
        if (ch >= 8'd1 && ch <= mrnp_pkg::CH_BLANK_MAX) begin
          count_next = cnt_bump;
        end else if (ch == mrnp_pkg::CH_0) begin
          phase_next = mrnp_pkg::PH_ZERO;
          count_next = cnt_bump;
        end else if (ch == mrnp_pkg::CH_LB || ch == mrnp_pkg::CH_UB) begin
          phase_next = mrnp_pkg::PH_BIN;
          seen_next  = 1'b0;
          count_next = cnt_bump;
        end else begin
          emit = dig_emit;
          if (dig_emit) begin
            phase_next = mrnp_pkg::PH_IDLE;
          end else begin
            phase_next = mrnp_pkg::PH_DEC;
            acc_next   = acc_step;
            seen_next  = 1'b1;
            count_next = cnt_bump;
          end
        end
      end
      mrnp_pkg::PH_ZERO: begin
        if (ch == mrnp_pkg::CH_LX || ch == mrnp_pkg::CH_UX) begin
          phase_next = mrnp_pkg::PH_HEX;
          seen_next  = 1'b0;
          count_next = cnt_bump;
        end else if (ok) begin
          // An octal digit can never overflow a zero accumulator.
          phase_next = mrnp_pkg::PH_OCT;
          acc_next   = acc_step;
          seen_next  = 1'b1;
          count_next = cnt_bump;
        end else begin
          emit       = 1'b1;
          phase_next = mrnp_pkg::PH_IDLE;
          result     = '{value: 32'd0, status: mrnp_pkg::ST_FOUND,
                         radix_kind: mrnp_pkg::RK_ZERO, consumed: cnt_sat};
        end
      end
      mrnp_pkg::PH_HEX, mrnp_pkg::PH_OCT, mrnp_pkg::PH_BIN, mrnp_pkg::PH_DEC: begin
        emit = dig_emit;
        if (dig_emit) begin
          phase_next = mrnp_pkg::PH_IDLE;
        end else begin
          acc_next   = acc_step;
          seen_next  = 1'b1;
          count_next = cnt_bump;
        end
      end
      default: begin
        phase_next = mrnp_pkg::PH_IDLE;
      end
    endcase
  end

endmodule
